// ===== rtl/sqpa_pkg.sv =====
package sqpa_pkg;

  // Octant bases in units of one, placed above the fraction bits.
  localparam logic [3:0] BASE_0 = 4'd0;
  localparam logic [3:0] BASE_2 = 4'd2;
  localparam logic [3:0] BASE_4 = 4'd4;
  localparam logic [3:0] BASE_6 = 4'd6;
  localparam logic [3:0] BASE_8 = 4'd8;

  // Classification of one word, carried next to the divider operands.
  typedef struct packed {
    logic [3:0] base;
    logic       add;
    logic       zero_vec;
  } ctrl_t;

endpackage

// ===== rtl/sqpa_front.sv =====
module sqpa_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic [COORD_WIDTH-1:0] x_coord,
  input  logic [COORD_WIDTH-1:0] y_coord,
  output logic [COORD_WIDTH-1:0] num,
  output logic [COORD_WIDTH-1:0] den,
  output sqpa_pkg::ctrl_t        ctrl
);
  import sqpa_pkg::*;

  logic                   x_neg;
  logic                   y_neg;
  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic                   x_ge;
  logic                   x_le;

  // Magnitudes; the most negative value maps to its unsigned magnitude.
  assign x_neg = x_coord[COORD_WIDTH-1];
  assign y_neg = y_coord[COORD_WIDTH-1];
  assign ax    = x_neg ? (~x_coord + 1'b1) : x_coord;
  assign ay    = y_neg ? (~y_coord + 1'b1) : y_coord;
  assign x_ge  = (ax >= ay);
  assign x_le  = (ax <= ay);

  // Pick the octant, its base and the operand order of the ratio.
  always_comb begin
    ctrl.zero_vec = (ax == '0) && (ay == '0);
    if (!y_neg && !x_neg) begin
      if (x_ge) begin
        ctrl.base = BASE_0; ctrl.add = 1'b1; num = ay; den = ax;
      end else begin
        ctrl.base = BASE_2; ctrl.add = 1'b0; num = ax; den = ay;
      end
    end else if (!y_neg) begin
      if (x_le) begin
        ctrl.base = BASE_2; ctrl.add = 1'b1; num = ax; den = ay;
      end else begin
        ctrl.base = BASE_4; ctrl.add = 1'b0; num = ay; den = ax;
      end
    end else if (x_neg || (ax == '0)) begin
      if (x_ge) begin
        ctrl.base = BASE_4; ctrl.add = 1'b1; num = ay; den = ax;
      end else begin
        ctrl.base = BASE_6; ctrl.add = 1'b0; num = ax; den = ay;
      end
    end else begin
      if (x_le) begin
        ctrl.base = BASE_6; ctrl.add = 1'b1; num = ax; den = ay;
      end else begin
        ctrl.base = BASE_8; ctrl.add = 1'b0; num = ay; den = ax;
      end
    end
  end

endmodule

// ===== rtl/sqpa_queue.sv =====
module sqpa_queue #(
  parameter int DATA_W = 38
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  // Two-entry queue; full and empty follow from the fill count.
  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_ready && out_valid;
  assign out_data  = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  // The count never runs past the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  // The pointers differ exactly when the queue holds one word.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr != rd_ptr) == (count == 2'd1))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/sqpa_back.sv =====
module sqpa_back #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] num,
  input  logic [COORD_WIDTH-1:0] den,
  input  sqpa_pkg::ctrl_t        ctrl,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRAC_BITS+3:0]   pseudo_angle,
  output logic                   undefined
);
  import sqpa_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int STG = F + 1;

  logic           en;
  logic [STG-1:0] vld;
  logic [W-1:0]   rem [STG];
  logic [W-1:0]   dvs [STG];
  logic [F:0]     quo [STG];
  ctrl_t          ctl [STG];
  logic           first_bit;
  logic [W-1:0]   first_rem;
  logic [F+3:0]   base_ext;
  logic [F+3:0]   quo_ext;

  // The whole pipeline moves when the output register is free or drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // First step: the ratio is at most one, so the integer bit is a compare.
  assign first_bit = (num >= den);
  assign first_rem = first_bit ? (num - den) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= first_rem;
      dvs[0] <= den;
      quo[0] <= {{F{1'b0}}, first_bit};
      ctl[0] <= ctrl;
    end
  end

  // One restoring step per stage for each fraction bit.
  for (genvar i = 1; i < STG; i++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       bit_q;

    assign trial = {rem[i-1], 1'b0};
    assign diff  = trial - {1'b0, dvs[i-1]};
    assign bit_q = (trial >= {1'b0, dvs[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= bit_q ? diff[W-1:0] : trial[W-1:0];
        dvs[i] <= dvs[i-1];
        quo[i] <= {quo[i-1][F-1:0], bit_q};
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[STG-2:0], in_valid};
      out_valid <= vld[STG-1];
    end
  end

  // Apply the quotient to the octant base.
  assign base_ext = {ctl[STG-1].base, {F{1'b0}}};
  assign quo_ext  = {3'b000, quo[STG-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      undefined <= ctl[STG-1].zero_vec;
      if (ctl[STG-1].zero_vec) begin
        pseudo_angle <= '0;
      end else if (ctl[STG-1].add) begin
        pseudo_angle <= base_ext + quo_ext;
      end else begin
        pseudo_angle <= base_ext - quo_ext;
      end
    end
  end

`ifndef SYNTHESIS
  // The zero vector always reads as angle zero.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && undefined |-> pseudo_angle == '0)
    else $error("zero vector gave a nonzero angle");
  // A result never exceeds eight.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pseudo_angle <= {BASE_8, {F{1'b0}}})
    else $error("pseudo angle above eight");
`endif

endmodule

// ===== rtl/square_pseudo_angle.sv =====
// Square pseudo-angle of a signed vector: a value in [0, 8] with FRAC_BITS
// fraction bits that rises with the polar angle counter-clockwise from the
// positive x axis; the zero vector gives 0 with undefined set. One word is
// accepted every cycle while the output side keeps up. An accepted word is
// held in the two-entry input queue, then moves through the FRAC_BITS + 1
// stages of the bit-per-stage restoring divider, whose last stage feeds the
// output register. A stall at the output halts the divider pipeline; the
// queue then absorbs up to two more words before in_ready falls.
module square_pseudo_angle #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] x_coord,
  input  logic [COORD_WIDTH-1:0] y_coord,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRAC_BITS+3:0]   pseudo_angle,
  output logic                   undefined
);
  import sqpa_pkg::*;

  localparam int DATA_W = 2 * COORD_WIDTH + $bits(ctrl_t);

  logic [COORD_WIDTH-1:0] f_num;
  logic [COORD_WIDTH-1:0] f_den;
  ctrl_t                  f_ctrl;
  logic [DATA_W-1:0]      q_data;
  logic                   q_valid;
  logic                   b_ready;
  logic [COORD_WIDTH-1:0] b_num;
  logic [COORD_WIDTH-1:0] b_den;
  ctrl_t                  b_ctrl;

  // Classify the incoming word.
  sqpa_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .x_coord(x_coord),
    .y_coord(y_coord),
    .num    (f_num),
    .den    (f_den),
    .ctrl   (f_ctrl)
  );

  // Queue between classification and division.
  sqpa_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  ({f_num, f_den, f_ctrl}),
    .out_valid(q_valid),
    .out_ready(b_ready),
    .out_data (q_data)
  );

  assign {b_num, b_den, b_ctrl} = q_data;

  // Divide and apply the octant base.
  sqpa_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (b_ready),
    .num         (b_num),
    .den         (b_den),
    .ctrl        (b_ctrl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pseudo_angle(pseudo_angle),
    .undefined   (undefined)
  );

endmodule

// ===== bench/square_pseudo_angle_tb.sv =====
`timescale 1ns / 100ps

module square_pseudo_angle_tb;
  import sqpa_pkg::*;

  localparam int COORD_WIDTH    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int ANGLE_WIDTH    = FRAC_BITS + 4;
  localparam int PIPE_LATENCY   = FRAC_BITS + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORDS_PER_PHASE = 406;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES    = 150;

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] angle;
    logic                   undef;
  } angle_result_t;

  // Expected angles of accepted words, oldest first, and the checks on them.
  class angle_scoreboard;
    angle_result_t pending_angles[$];
    int errors = 0;

    // Octant from the signs and magnitudes, then base plus or minus the
    // truncated quotient of the smaller magnitude over the larger one.
    function angle_result_t pseudo_angle_of(logic [COORD_WIDTH-1:0] x,
                                            logic [COORD_WIDTH-1:0] y);
      longint xs, ys, ax, ay, num, den, quot, base_fixed;
      logic [3:0] base;
      bit add;
      angle_result_t r;
      xs = longint'($signed(x));
      ys = longint'($signed(y));
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;
      r.angle = '0;
      r.undef = 1'b0;
      if (ax == 0 && ay == 0) begin
        r.undef = 1'b1;
        return r;
      end
      if (ys >= 0) begin
        if (xs >= 0) begin
          if (ax >= ay) begin base = BASE_0; add = 1; num = ay; den = ax; end
          else begin base = BASE_2; add = 0; num = ax; den = ay; end
        end else begin
          if (ax <= ay) begin base = BASE_2; add = 1; num = ax; den = ay; end
          else begin base = BASE_4; add = 0; num = ay; den = ax; end
        end
      end else begin
        // The negative y axis belongs to the third quadrant's octants.
        if (xs < 0 || ax == 0) begin
          if (ax >= ay) begin base = BASE_4; add = 1; num = ay; den = ax; end
          else begin base = BASE_6; add = 0; num = ax; den = ay; end
        end else begin
          if (ax <= ay) begin base = BASE_6; add = 1; num = ax; den = ay; end
          else begin base = BASE_8; add = 0; num = ay; den = ax; end
        end
      end
      quot = (num << FRAC_BITS) / den;
      base_fixed = longint'(base) << FRAC_BITS;
      r.angle = ANGLE_WIDTH'(add ? base_fixed + quot : base_fixed - quot);
      return r;
    endfunction

    function void note_vector(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
      pending_angles.push_back(pseudo_angle_of(x, y));
    endfunction

    function void check_angle(logic [ANGLE_WIDTH-1:0] angle, logic undef);
      angle_result_t want;
      if (pending_angles.size() == 0) begin
        $error("result with no word pending: pseudo_angle %0d undefined %0b",
               angle, undef);
        errors++;
        return;
      end
      want = pending_angles.pop_front();
      if (angle !== want.angle) begin
        $error("pseudo_angle: expected %0d, got %0d", want.angle, angle);
        errors++;
      end
      if (undef !== want.undef) begin
        $error("undefined: expected %0b, got %0b", want.undef, undef);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [COORD_WIDTH-1:0] x_coord = '0;
  logic [COORD_WIDTH-1:0] y_coord = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ANGLE_WIDTH-1:0] pseudo_angle;
  logic                   undefined;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;

  angle_scoreboard angles = new();

  square_pseudo_angle #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pseudo_angle(pseudo_angle),
    .undefined   (undefined)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: check each accepted word, then decide the next ready. Once,
  // the receiver holds off for a long stretch so the pipeline backs up.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      angles.check_angle(pseudo_angle, undefined);
      results_seen++;
    end
    if (results_seen == HOLD_AT_RESULT && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one word after a random idle gap and wait for it to be taken.
  task automatic send_vector(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= x;
    y_coord  <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angles.note_vector(x, y);
  endtask

  // Mix of full-range vectors, tiny ones, diagonals, axes and extremes.
  task automatic send_random_vector();
    logic [COORD_WIDTH-1:0] x, y, m;
    logic [COORD_WIDTH-1:0] corners[5];
    corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
    x = COORD_WIDTH'($urandom);
    y = COORD_WIDTH'($urandom);
    case ($urandom_range(9))
      0, 1: begin
        x = COORD_WIDTH'($urandom_range(8)) - COORD_WIDTH'(4);
        y = COORD_WIDTH'($urandom_range(8)) - COORD_WIDTH'(4);
      end
      2: begin
        m = COORD_WIDTH'($urandom_range(32768, 1));
        x = $urandom_range(1) ? -m : m;
        y = $urandom_range(1) ? -m : m;
      end
      3: begin
        if ($urandom_range(1)) x = '0;
        else y = '0;
      end
      4: begin
        x = corners[$urandom_range(4)];
        y = corners[$urandom_range(4)];
      end
      default: ;
    endcase
    send_vector(x, y);
  endtask

  // Axes, diagonals, octant borders, full-scale corners and the zero vector.
  int dir_x[$] = '{0, 1, 0, -1, 0, 32767, -32768, -32768, 32767, -32768, 0,
                   32767, 1, -1, 1, 32767, -32768, 1, -1, -1, 1, 3, -2, 21845};
  int dir_y[$] = '{0, 0, 1, 0, -1, 32767, -32768, 32767, -32768, 0, -32768,
                   1, 32767, -32768, -32768, -1, 1, 1, 1, -1, -1, -2, 3, -21846};

  initial begin
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 80, 0, 17};
    stall_pct = '{0, 0, 80, 17};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_x[i]) send_vector(COORD_WIDTH'(dir_x[i]), COORD_WIDTH'(dir_y[i]));

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (WORDS_PER_PHASE) send_random_vector();
    end

    // Drain, then give stray results time to show up.
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (angles.pending_angles.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (angles.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
